// File: hdl/matrix4x4_multiply_defines.svh
// Assertion macros for the 4x4 matrix multiplier.
// Included by the top level; no other dependencies.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF
`define MM4_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define MM4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MM4_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define MM4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hdl/mm4_pkg.sv
// Shared types and constants for the 4x4 matrix multiplier.
// No dependencies; used by every module of the block.
package mm4_pkg;

    localparam int unsigned IDX_W  = 4;
    localparam int unsigned TERM_W = 2;

    localparam logic [IDX_W-1:0]  LAST_IDX  = 4'hF;
    localparam logic [TERM_W-1:0] LAST_TERM = 2'd3;
    localparam logic [TERM_W-1:0] FIRST_TERM = 2'd0;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT,
        S_PUSH
    } t_state;

    // Control that travels alongside a store read into the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctrl;

endpackage

// File: hdl/matrix4x4_multiply.sv
// Top level of the 4x4 fixed-point matrix multiplier, out = a * b.
// Depends on mm4_pkg, mm4_store, mm4_mac, mm4_seq and the defines header.
//
//  Channel   Dir  Handshake                          Contents
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  a_value, b_value
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  out_value, out_index, tlast
//
// Loading accepts one transaction per cycle for the sixteen element pairs.
// After the sixteenth, the single shared multiply-accumulate forms the 64
// products; for each result element the sequencer issues four store reads,
// which pass through the read, multiply and accumulate registers, and then
// waits for the accumulation to finish before pushing the result.
// The input is not ready during that phase. A stalled output holds the
// sequencer before the next element. Reset is synchronous and active low
// and clears the sequencer and the valid flags; store contents are not reset.
`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input transactions: tdata holds a_value from bit 0, then b_value.
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]           i_s_axis_tdata,
    // Output transactions: tdata holds out_value from bit 0, then out_index.
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    output logic [((DATA_WIDTH+mm4_pkg::IDX_W+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                                        o_m_axis_tlast
);

    localparam int unsigned OUT_TDATA_W = ((DATA_WIDTH + mm4_pkg::IDX_W + 7) / 8) * 8;

    logic                       w_in_ready;
    logic                       w_wr_en;
    logic [mm4_pkg::IDX_W-1:0]  w_wr_addr;
    logic [mm4_pkg::IDX_W-1:0]  w_rd_addr_a;
    logic [mm4_pkg::IDX_W-1:0]  w_rd_addr_b;
    mm4_pkg::t_mac_ctrl         w_ctrl;
    logic                       w_push;
    logic [mm4_pkg::IDX_W-1:0]  w_elem;
    logic [DATA_WIDTH-1:0]      w_rd_a;
    logic [DATA_WIDTH-1:0]      w_rd_b;
    logic                       w_mac_done;
    logic [DATA_WIDTH-1:0]      w_result;
    logic                       w_out_free;

    logic                       r_out_valid;
    logic [DATA_WIDTH-1:0]      r_out_value;
    logic [mm4_pkg::IDX_W-1:0]  r_out_index;

    // The output slot is free when empty or when its transaction completes now.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    mm4_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_mac_done  (w_mac_done),
        .i_out_free  (w_out_free),
        .o_in_ready  (w_in_ready),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr_a (w_rd_addr_a),
        .o_rd_addr_b (w_rd_addr_b),
        .o_ctrl      (w_ctrl),
        .o_push      (w_push),
        .o_elem      (w_elem)
    );

    mm4_store #(.DATA_WIDTH(DATA_WIDTH)) u_left_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_s_axis_tdata[DATA_WIDTH-1:0]),
        .i_rd_en   (w_ctrl.valid),
        .i_rd_addr (w_rd_addr_a),
        .o_rd_data (w_rd_a)
    );

    mm4_store #(.DATA_WIDTH(DATA_WIDTH)) u_right_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_rd_en   (w_ctrl.valid),
        .i_rd_addr (w_rd_addr_b),
        .o_rd_data (w_rd_b)
    );

    mm4_mac #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_a      (w_rd_a),
        .i_b      (w_rd_b),
        .o_done   (w_mac_done),
        .o_result (w_result)
    );

    // Output register: the accumulator holds its result until it is pushed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_value <= w_result;
            r_out_index <= w_elem;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_index, r_out_value});
    assign o_m_axis_tlast  = (r_out_index == mm4_pkg::LAST_IDX);

    // A result is only pushed into a free output slot.
    `MM4_ASSERT_SAME(a_push_free, i_clk, i_rst_n, w_push, w_out_free, "push into busy output")
    // Loading and product reads never overlap.
    `MM4_ASSERT_SAME(a_load_excl, i_clk, i_rst_n, o_s_axis_tready, !w_ctrl.valid, "load during compute")
    // After the last result is pushed the block is back to loading.
    `MM4_ASSERT_NEXT(a_last_load, i_clk, i_rst_n, w_push && (w_elem == mm4_pkg::LAST_IDX), o_s_axis_tready, "no return to load")

endmodule

// File: hdl/mm4_store.sv
// One 16-entry element store with a write port and a registered read port.
// Depends on mm4_pkg for the index width.
module mm4_store #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [mm4_pkg::IDX_W-1:0]   i_wr_addr,
    input  logic [DATA_WIDTH-1:0]       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [mm4_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [DATA_WIDTH-1:0]       o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [0:(1 << mm4_pkg::IDX_W)-1];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/mm4_mac.sv
// Shared multiply-accumulate unit with shift and saturation of the sum.
// Depends on mm4_pkg for the control struct.
module mm4_mac #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mm4_pkg::t_mac_ctrl      i_ctrl,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    output logic                    o_done,
    output logic [DATA_WIDTH-1:0]   o_result
);

    localparam int unsigned PROD_W = 2 * DATA_WIDTH;
    localparam int unsigned ACC_W  = PROD_W + 2;

    mm4_pkg::t_mac_ctrl         r_ctrl1;
    mm4_pkg::t_mac_ctrl         r_ctrl2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_done;

    logic signed [DATA_WIDTH-1:0] w_a;
    logic signed [DATA_WIDTH-1:0] w_b;
    logic signed [PROD_W-1:0]     n_prod;
    logic signed [ACC_W-1:0]      w_prod_ext;
    logic signed [ACC_W-1:0]      w_shifted;
    logic                         w_fits;
    logic [DATA_WIDTH-1:0]        w_max;
    logic [DATA_WIDTH-1:0]        w_min;

    assign w_a        = signed'(i_a);
    assign w_b        = signed'(i_b);
    assign n_prod     = w_a * w_b;
    assign w_prod_ext = {{2{r_prod[PROD_W-1]}}, r_prod};

    // The control word is registered in step with the store read, then with the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ctrl1 <= i_ctrl;
            r_ctrl2 <= r_ctrl1;
            if (r_ctrl2.valid) begin
                r_done <= r_ctrl2.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctrl1.valid) begin
            r_prod <= n_prod;
        end
        if (r_ctrl2.valid) begin
            r_acc <= r_ctrl2.first ? w_prod_ext : (r_acc + w_prod_ext);
        end
    end

    // Arithmetic shift truncates towards minus infinity, then clamp.
    assign w_shifted = r_acc >>> FRAC_BITS;
    assign w_fits    = (&w_shifted[ACC_W-1:DATA_WIDTH-1]) ||
                       (~|w_shifted[ACC_W-1:DATA_WIDTH-1]);
    assign w_max     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    assign w_min     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    assign o_result  = w_fits ? w_shifted[DATA_WIDTH-1:0]
                              : (w_shifted[ACC_W-1] ? w_min : w_max);
    assign o_done    = r_done;

endmodule

// File: hdl/mm4_seq.sv
// Sequencer: loads the element stores, then walks the 64 products.
// Depends on mm4_pkg for the state type, control struct and constants.
module mm4_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_mac_done,
    input  logic                        i_out_free,
    output logic                        o_in_ready,
    output logic                        o_wr_en,
    output logic [mm4_pkg::IDX_W-1:0]   o_wr_addr,
    output logic [mm4_pkg::IDX_W-1:0]   o_rd_addr_a,
    output logic [mm4_pkg::IDX_W-1:0]   o_rd_addr_b,
    output mm4_pkg::t_mac_ctrl          o_ctrl,
    output logic                        o_push,
    output logic [mm4_pkg::IDX_W-1:0]   o_elem
);

    mm4_pkg::t_state               r_state, n_state;
    logic [mm4_pkg::IDX_W-1:0]     r_load_cnt, n_load_cnt;
    logic [mm4_pkg::IDX_W-1:0]     r_elem, n_elem;
    logic [mm4_pkg::TERM_W-1:0]    r_term, n_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mm4_pkg::S_LOAD;
            r_load_cnt <= '0;
            r_elem     <= '0;
            r_term     <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_elem     <= n_elem;
            r_term     <= n_term;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_elem     = r_elem;
        n_term     = r_term;
        o_in_ready = 1'b0;
        o_wr_en    = 1'b0;
        o_ctrl     = '0;
        o_push     = 1'b0;
        unique case (r_state)
            mm4_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_wr_en    = 1'b1;
                    n_load_cnt = r_load_cnt + 1'b1;
                    if (r_load_cnt == mm4_pkg::LAST_IDX) begin
                        n_state = mm4_pkg::S_ISSUE;
                        n_elem  = '0;
                        n_term  = mm4_pkg::FIRST_TERM;
                    end
                end
            end
            mm4_pkg::S_ISSUE: begin
                o_ctrl.valid = 1'b1;
                o_ctrl.first = (r_term == mm4_pkg::FIRST_TERM);
                o_ctrl.last  = (r_term == mm4_pkg::LAST_TERM);
                n_term       = r_term + 1'b1;
                if (r_term == mm4_pkg::LAST_TERM) begin
                    n_state = mm4_pkg::S_WAIT;
                end
            end
            mm4_pkg::S_WAIT: begin
                if (i_mac_done) begin
                    n_state = mm4_pkg::S_PUSH;
                end
            end
            mm4_pkg::S_PUSH: begin
                if (i_out_free) begin
                    o_push = 1'b1;
                    n_elem = r_elem + 1'b1;
                    if (r_elem == mm4_pkg::LAST_IDX) begin
                        n_state = mm4_pkg::S_LOAD;
                    end else begin
                        n_state = mm4_pkg::S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = mm4_pkg::S_LOAD;
            end
        endcase
    end

    // Column-major: a[row][k] sits at {k,row}, b[k][col] at {col,k}.
    assign o_wr_addr   = r_load_cnt;
    assign o_rd_addr_a = {r_term, r_elem[1:0]};
    assign o_rd_addr_b = {r_elem[3:2], r_term};
    assign o_elem      = r_elem;

endmodule

// File: tb/matrix4x4_multiply_tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
// Drives element pairs as frames of sixteen transactions and checks every product element
// against its own predictor. Depends on mm4_pkg and the matrix4x4_multiply RTL.
module matrix4x4_multiply_tb;

    localparam int DW          = 32;
    localparam int FB          = 16;
    localparam int IW          = mm4_pkg::IDX_W;
    localparam int IN_TDATA_W  = ((2*DW+7)/8)*8;
    localparam int OUT_TDATA_W = ((DW+IW+7)/8)*8;
    localparam int RAND_FRAMES = 16;
    localparam int DRAIN_FRAME = 6;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYC  = 150;

    localparam logic [DW-1:0] ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ELEM_ONE = DW'(1) << FB;

    // One element of a and the element of b at the same index; the drain flag holds the
    // sender back until every outstanding product element has been received.
    typedef struct {
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        bit            drain;
    } t_elem_pair;

    typedef struct {
        logic [DW-1:0] value;
        logic [IW-1:0] index;
        logic          last;
    } t_product_elem;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // a_value, b_value
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // out_value, out_index, zero padding
    logic                   o_m_axis_tlast;

    t_elem_pair    pending_pairs[$];
    t_product_elem expected_elems[$];

    // The predictor's own copy of the two matrices and the load position.
    logic signed [DW-1:0] left_elems[16];
    logic signed [DW-1:0] right_elems[16];
    int                   load_idx      = 0;

    int  results_owed   = 0;   // product elements predicted, kept by the driver
    int  results_seen   = 0;   // product elements received, kept by the monitor
    int  mismatch_count = 0;
    int  stuck_cycles   = 0;
    int  cyc_count      = 0;

    wire s_fire = i_s_axis_tvalid && o_s_axis_tready;
    wire m_fire = o_m_axis_tvalid && i_m_axis_tready;

    matrix4x4_multiply #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Element (row, col) of a * b, column-major: a dot product of row of a with column of b,
    // summed exactly, shifted arithmetically (so truncated towards minus infinity) and
    // clamped to the signed element range.
    function automatic logic [DW-1:0] product_element(input int idx);
        logic signed [127:0] acc;
        logic signed [127:0] sat_hi;
        logic signed [127:0] sat_lo;
        int                  row;
        int                  col;
        row    = idx % 4;
        col    = idx / 4;
        acc    = '0;
        sat_hi = (128'sd1 <<< (DW-1)) - 128'sd1;
        sat_lo = -(128'sd1 <<< (DW-1));
        for (int k = 0; k < 4; k++) begin
            acc = acc + left_elems[k*4 + row] * right_elems[col*4 + k];
        end
        acc = acc >>> FB;
        if (acc > sat_hi) begin
            return ELEM_MAX;
        end
        if (acc < sat_lo) begin
            return ELEM_MIN;
        end
        return acc[DW-1:0];
    endfunction

    // Random element: modest Q16.16 values, whose sums stay in range, for three picks
    // in ten; the extremes, zero, plus or minus one and full-width patterns make up the rest.
    function automatic logic [DW-1:0] random_elem();
        int pick;
        int span;
        pick = $urandom_range(0, 9);
        span = $urandom_range(0, 1 << 20);
        case (pick)
            0: begin
                return ELEM_MAX;
            end
            1: begin
                return ELEM_MIN;
            end
            2: begin
                return '0;
            end
            3, 4, 5: begin
                return DW'(span - (1 << 19));
            end
            6: begin
                return $urandom_range(0, 1) ? ELEM_ONE : -ELEM_ONE;
            end
            default: begin
                return DW'($urandom);
            end
        endcase
    endfunction

    // Both sides take breaks at a chance of 14 in a hundred, except during a long
    // stretch in the middle of the run where they never do.
    function automatic bit take_break();
        if (cyc_count >= 1000 && cyc_count < 1800) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 14;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Driver. A transaction is held until it is accepted; a new one is presented only
    // when the previous one has gone. Every accepted pair goes into the predictor's
    // matrices, and the sixteenth of a frame produces the sixteen expected elements.
    always @(posedge i_clk) begin : drive_pairs
        t_elem_pair nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (s_fire) begin
                left_elems[load_idx]  = i_s_axis_tdata[0 +: DW];
                right_elems[load_idx] = i_s_axis_tdata[DW +: DW];
                if (load_idx == 15) begin
                    for (int i = 0; i < 16; i++) begin
                        expected_elems.push_back('{product_element(i), IW'(i),
                                                   IW'(i) == mm4_pkg::LAST_IDX});
                    end
                    results_owed = results_owed + 16;
                    load_idx = 0;
                end else begin
                    load_idx = load_idx + 1;
                end
            end
            if (!i_s_axis_tvalid || s_fire) begin
                if (pending_pairs.size() != 0 && !take_break() &&
                    (!pending_pairs[0].drain || results_seen == results_owed)) begin
                    nxt = pending_pairs.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {nxt.b, nxt.a};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted product element is compared, field by field, with the
    // oldest expectation; the ready line is dropped at random to stall the block.
    always @(posedge i_clk) begin : check_products
        t_product_elem want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (m_fire) begin
                results_seen <= results_seen + 1;
                if (expected_elems.size() == 0) begin
                    report_mismatch($sformatf("unexpected element, tdata %h",
                                              o_m_axis_tdata));
                end else begin
                    want = expected_elems.pop_front();
                    if (o_m_axis_tdata[0 +: DW] !== want.value) begin
                        report_mismatch($sformatf("index %0d value %h, expected %h",
                                                  want.index, o_m_axis_tdata[0 +: DW],
                                                  want.value));
                    end
                    if (o_m_axis_tdata[DW +: IW] !== want.index) begin
                        report_mismatch($sformatf("index field %0d, expected %0d",
                                                  o_m_axis_tdata[DW +: IW], want.index));
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("index %0d tlast %b, expected %b",
                                                  want.index, o_m_axis_tlast, want.last));
                    end
                end
            end
            i_m_axis_tready <= !take_break();
        end
    end

    // Watchdog: the run is abandoned if no transaction moves on either side for too long.
    // A frame's compute phase with every result stalled stays well inside the limit.
    always @(posedge i_clk) begin : watchdog
        cyc_count <= cyc_count + 1;
        if (!i_rst_n || s_fire || m_fire) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        int r;
        int c;
        logic [DW-1:0] a_val;
        logic [DW-1:0] b_val;

        // Directed frame. Rows of a are all maximum, all minimum, all zero and all the
        // smallest negative step; columns of b are all maximum, all minimum, all 1.0 and
        // the smallest positive step. This drives saturation at both ends, zero results,
        // exact scaling by one, and a small negative sum that truncates down to -1.
        for (int i = 0; i < 16; i++) begin
            r = i % 4;
            c = i / 4;
            case (r)
                0: a_val = ELEM_MAX;
                1: a_val = ELEM_MIN;
                2: a_val = '0;
                default: a_val = '1;
            endcase
            case (c)
                0: b_val = ELEM_MAX;
                1: b_val = ELEM_MIN;
                2: b_val = ELEM_ONE;
                default: b_val = DW'(1);
            endcase
            pending_pairs.push_back('{a_val, b_val, 1'b0});
        end

        // Random frames; one of them waits for the previous frame to drain completely.
        for (int f = 0; f < RAND_FRAMES; f++) begin
            for (int i = 0; i < 16; i++) begin
                pending_pairs.push_back('{random_elem(), random_elem(),
                                          (f == DRAIN_FRAME) && (i == 0)});
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || i_s_axis_tvalid || expected_elems.size() != 0) begin
            @(posedge i_clk);
        end
        // Allow for any stray output the block might still produce.
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mm4_pkg.sv
hdl/mm4_store.sv
hdl/mm4_mac.sv
hdl/mm4_seq.sv
hdl/matrix4x4_multiply.sv
tb/matrix4x4_multiply_tb.sv
